@@ sv/hough_line_accumulator_assert.svh @@
// Assertion macros used by the checker of the Hough line accumulator.
`ifndef HOUGH_LINE_ACCUMULATOR_ASSERT_SVH
`define HOUGH_LINE_ACCUMULATOR_ASSERT_SVH

// Check a condition on every rising clock edge outside reset.
`define HLA_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define HLA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define HLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/hla_pkg.sv @@
// Package of the Hough line accumulator: constants, trig builder, control types.
package hla_pkg;

  localparam int THETA_BINS_DEF = 128;
  localparam int RHO_BINS_DEF   = 256;
  localparam int VOTE_BITS_DEF  = 32;

  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHO_OFFSET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RHO_SCALE    = 2'd3;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd480;
  localparam logic [25:0] RHO_OFFSET_RST   = 26'd26214400;
  localparam logic [23:0] RHO_SCALE_RST    = 24'd20972;

  localparam longint unsigned PI_Q30  = 64'hC90FDAA2;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam int SERIES_TERMS = 14;

  localparam longint unsigned SIN_DIV [SERIES_TERMS] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702, 812};
  localparam longint unsigned COS_DIV [SERIES_TERMS] =
    '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650, 756};

  // Taylor series in Q2.30 on an angle in [0, pi/2]; returns magnitude in 2^-15 units.
  function automatic logic [16:0] taylor_q15(longint unsigned x, bit is_cos);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = is_cos ? ONE_Q30 : x;
    sum  = longint'(term);
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      if (is_cos) begin
        term = ((term * x2) >> 30) / COS_DIV[n-1];
      end else begin
        term = ((term * x2) >> 30) / SIN_DIV[n-1];
      end
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32768) begin
      sum = 32768;
    end
    return 17'(sum);
  endfunction

  typedef struct packed {
    logic load;
    logic clr_go;
    logic vote_go;
    logic srch_go;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

endpackage

@@ sv/hla_ctrl.sv @@
// Controller of the Hough line accumulator: sequences clear, vote, search and emit.
module hla_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          item_first,
  input  logic          item_last,
  input  logic          item_nz,
  input  hla_pkg::sts_t sts,
  output hla_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CLR_GO    = 3'd1;
  localparam logic [2:0] ST_CLR_WAIT  = 3'd2;
  localparam logic [2:0] ST_VOTE_GO   = 3'd3;
  localparam logic [2:0] ST_VOTE_WAIT = 3'd4;
  localparam logic [2:0] ST_SRCH_GO   = 3'd5;
  localparam logic [2:0] ST_SRCH_WAIT = 3'd6;
  localparam logic [2:0] ST_EMIT      = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       nz_r, nz_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    nz_nxt    = nz_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          last_nxt = item_last;
          nz_nxt   = item_nz;
          if (item_first) begin
            state_nxt = ST_CLR_GO;
          end else if (item_nz) begin
            state_nxt = ST_VOTE_GO;
          end else if (item_last) begin
            state_nxt = ST_SRCH_GO;
          end
        end
      end
      ST_CLR_GO: begin
        cmd.clr_go = 1'b1;
        state_nxt  = ST_CLR_WAIT;
      end
      ST_CLR_WAIT: begin
        if (!sts.busy) begin
          if (nz_r) begin
            state_nxt = ST_VOTE_GO;
          end else if (last_r) begin
            state_nxt = ST_SRCH_GO;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_VOTE_GO: begin
        cmd.vote_go = 1'b1;
        state_nxt   = ST_VOTE_WAIT;
      end
      ST_VOTE_WAIT: begin
        if (!sts.busy) begin
          state_nxt = last_r ? ST_SRCH_GO : ST_IDLE;
        end
      end
      ST_SRCH_GO: begin
        cmd.srch_go = 1'b1;
        state_nxt   = ST_SRCH_WAIT;
      end
      ST_SRCH_WAIT: begin
        if (!sts.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR_GO;
      last_r  <= 1'b0;
      nz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      nz_r    <= nz_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

endmodule

@@ sv/hla_dp.sv @@
// Datapath of the Hough line accumulator: config, trig table, vote pipeline, store, search.
module hla_dp #(
  parameter int THETA_BINS = hla_pkg::THETA_BINS_DEF,
  parameter int RHO_BINS   = hla_pkg::RHO_BINS_DEF,
  parameter int VOTE_BITS  = hla_pkg::VOTE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hla_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [7:0]                    pixel_value,
  input  logic [9:0]                    pos_x,
  input  logic [9:0]                    pos_y,
  input  hla_pkg::cmd_t                 cmd,
  output hla_pkg::sts_t                 sts,
  output logic [6:0]                    peak_theta_index,
  output logic [7:0]                    peak_rho_index,
  output logic [31:0]                   peak_votes,
  output logic                          votes_saturated
);

  localparam int TOTAL  = THETA_BINS * RHO_BINS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int TW     = $clog2(THETA_BINS);
  localparam int RW     = $clog2(RHO_BINS);
  localparam int EXT_W  = VOTE_BITS + 32;
  localparam logic [VOTE_BITS-1:0] VMAX = {VOTE_BITS{1'b1}};

  // Sine and cosine per theta bin, built at elaboration.
  logic signed [16:0] sin_tab [THETA_BINS];
  logic signed [16:0] cos_tab [THETA_BINS];

  for (genvar g = 0; g < THETA_BINS; g++) begin : g_trig
    localparam bit FLIP = (2 * g > THETA_BINS);
    localparam longint unsigned KQ = FLIP ? longint'(THETA_BINS - g) : longint'(g);
    localparam longint unsigned XQ = (hla_pkg::PI_Q30 * KQ) / THETA_BINS;
    localparam logic [16:0] SM = hla_pkg::taylor_q15(XQ, 1'b0);
    localparam logic [16:0] CM = hla_pkg::taylor_q15(XQ, 1'b1);
    assign sin_tab[g] = $signed(SM);
    assign cos_tab[g] = FLIP ? -$signed(CM) : $signed(CM);
  end

  // Configuration registers.
  logic [10:0] width_r, height_r;
  logic [25:0] offs_r;
  logic [23:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= hla_pkg::IMAGE_WIDTH_RST;
      height_r <= hla_pkg::IMAGE_HEIGHT_RST;
      offs_r   <= hla_pkg::RHO_OFFSET_RST;
      scale_r  <= hla_pkg::RHO_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hla_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[10:0];
        hla_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata[10:0];
        hla_pkg::REG_RHO_OFFSET:   offs_r   <= cfg_wdata[25:0];
        hla_pkg::REG_RHO_SCALE:    scale_r  <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Item registers.
  logic signed [11:0] dx_r, dy_r;
  logic [7:0]         val_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r  <= $signed({2'b00, pos_x}) - $signed({2'b00, width_r[10:1]});
      dy_r  <= $signed({2'b00, pos_y}) - $signed({2'b00, height_r[10:1]});
      val_r <= pixel_value;
    end
  end

  // Control registers of the sweeps and the vote pipeline.
  logic              clr_act_r, srch_act_r, iss_r;
  logic [ADDR_W-1:0] cnt_r;
  logic [TW-1:0]     st_r, th_r;
  logic [RW-1:0]     sr_r;
  logic              v1_r, v2_r, v3_r, v4_r, v5_r, sv_r;
  logic              sat_r;

  logic [TW-1:0]           th1_r, th2_r, th3_r;
  logic signed [28:0]      ps_r, pc_r;
  logic signed [33:0]      s_r;
  logic [56:0]             prod_r;
  logic [ADDR_W-1:0]       va_r, wa_r;
  logic [VOTE_BITS-1:0]    rd_r;
  logic [TW-1:0]           sbt_r, bt_r;
  logic [RW-1:0]           sbr_r, br_r;
  logic [VOTE_BITS-1:0]    best_r;

  logic signed [28:0]      ps_nxt, pc_nxt;
  logic signed [33:0]      s_nxt;
  logic [32:0]             spos;
  logic [56:0]             prod_nxt;
  logic [24:0]             binw;
  logic [RW-1:0]           bin;
  logic [ADDR_W-1:0]       va_nxt;
  logic [VOTE_BITS:0]      sum;
  logic                    sum_sat;
  logic [ADDR_W-1:0]       raddr;
  logic                    last_cnt;

  assign ps_nxt   = 29'(dx_r) * 29'(sin_tab[th_r]);
  assign pc_nxt   = 29'(dy_r) * 29'(cos_tab[th_r]);
  assign s_nxt    = ((34'(ps_r) - 34'(pc_r)) <<< 1) + $signed({8'b0, offs_r});
  assign spos     = (s_r > 34'sd0) ? s_r[32:0] : '0;
  assign prod_nxt = 57'(spos) * 57'(scale_r);
  assign binw     = prod_r[56:32];
  assign bin      = (binw > 25'(RHO_BINS - 1)) ? RW'(RHO_BINS - 1) : RW'(binw);
  assign va_nxt   = ADDR_W'(th3_r) * ADDR_W'(RHO_BINS) + ADDR_W'(bin);
  assign sum      = {1'b0, rd_r} + (VOTE_BITS+1)'(val_r);
  assign sum_sat  = (sum >= {1'b0, VMAX});
  assign raddr    = srch_act_r ? cnt_r : va_r;
  assign last_cnt = (cnt_r == ADDR_W'(TOTAL - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r  <= 1'b0;
      srch_act_r <= 1'b0;
      iss_r      <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      sv_r       <= 1'b0;
      sat_r      <= 1'b0;
      cnt_r      <= '0;
      st_r       <= '0;
      sr_r       <= '0;
      th_r       <= '0;
    end else begin
      // Sweep counter shared by clear and search.
      if (cmd.clr_go || cmd.srch_go) begin
        cnt_r <= '0;
        st_r  <= '0;
        sr_r  <= '0;
      end else if (clr_act_r || srch_act_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (sr_r == RW'(RHO_BINS - 1)) begin
          sr_r <= '0;
          st_r <= st_r + 1'b1;
        end else begin
          sr_r <= sr_r + 1'b1;
        end
      end
      if (cmd.clr_go) begin
        clr_act_r <= 1'b1;
      end else if (last_cnt) begin
        clr_act_r <= 1'b0;
      end
      if (cmd.srch_go) begin
        srch_act_r <= 1'b1;
      end else if (last_cnt) begin
        srch_act_r <= 1'b0;
      end
      sv_r <= srch_act_r;
      // Issue one theta bin a cycle.
      if (cmd.vote_go) begin
        iss_r <= 1'b1;
        th_r  <= '0;
      end else if (iss_r) begin
        if (th_r == TW'(THETA_BINS - 1)) begin
          iss_r <= 1'b0;
        end
        th_r <= th_r + 1'b1;
      end
      v1_r <= iss_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (cmd.clr_go) begin
        sat_r <= 1'b0;
      end else if (v5_r && sum_sat) begin
        sat_r <= 1'b1;
      end
    end
  end

  // Vote pipeline payload.
  always_ff @(posedge clk) begin
    th1_r  <= th_r;
    ps_r   <= ps_nxt;
    pc_r   <= pc_nxt;
    th2_r  <= th1_r;
    s_r    <= s_nxt;
    th3_r  <= th2_r;
    prod_r <= prod_nxt;
    va_r   <= va_nxt;
    wa_r   <= va_r;
    sbt_r  <= st_r;
    sbr_r  <= sr_r;
  end

  // Vote store: one write port, one registered read port.
  logic [VOTE_BITS-1:0] mem [TOTAL];

  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      mem[cnt_r] <= '0;
    end else if (v5_r) begin
      mem[wa_r] <= sum_sat ? VMAX : sum[VOTE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
  end

  // Running maximum; strict compare keeps the first peak.
  always_ff @(posedge clk) begin
    if (cmd.srch_go) begin
      best_r <= '0;
      bt_r   <= '0;
      br_r   <= '0;
    end else if (sv_r && (rd_r > best_r)) begin
      best_r <= rd_r;
      bt_r   <= sbt_r;
      br_r   <= sbr_r;
    end
  end

  logic [EXT_W-1:0] best_ext;
  assign best_ext = EXT_W'(best_r);

  assign peak_theta_index = 7'(bt_r);
  assign peak_rho_index   = 8'(br_r);
  assign peak_votes       = (best_ext > EXT_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : 32'(best_ext);
  assign votes_saturated  = sat_r;

  assign sts.busy = clr_act_r | srch_act_r | iss_r | v1_r | v2_r | v3_r | v4_r | v5_r | sv_r;

endmodule

@@ sv/hough_line_accumulator.sv @@
// Top level of the Hough line accumulator: controller plus datapath.
// Busy after accept: none for a blank pixel without marks; a voting pixel keeps busy high until
// all of its votes are written, so the next voting pixel is only taken after that.
// Frame first adds a clear sweep of the whole store ahead of the votes; frame
// last adds a search of the whole store, then the one-cycle result strobe.
// Reset (sync, rst_n low) loads defaults and then clears the whole store.
module hough_line_accumulator #(
  parameter int THETA_BINS = hla_pkg::THETA_BINS_DEF,
  parameter int RHO_BINS   = hla_pkg::RHO_BINS_DEF,
  parameter int VOTE_BITS  = hla_pkg::VOTE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [hla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hla_pkg::CFG_W-1:0]     cfg_wdata,
  // item command
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_pixel_value,
  input  logic [9:0]                    in_pos_x,
  input  logic [9:0]                    in_pos_y,
  input  logic                          in_frame_first,
  input  logic                          in_frame_last,
  // result strobe
  output logic                          out_valid,
  output logic [6:0]                    out_peak_theta_index,
  output logic [7:0]                    out_peak_rho_index,
  output logic [31:0]                   out_peak_votes,
  output logic                          out_votes_saturated
);

  hla_pkg::cmd_t cmd;
  hla_pkg::sts_t sts;
  logic          ctrl_start;

  // Take an item only while the controller is idle.
  assign ctrl_start = start & ~busy;

  hla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (ctrl_start),
    .item_first (in_frame_first),
    .item_last  (in_frame_last),
    .item_nz    (in_pixel_value != 8'd0),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  // Hold config, trig table, vote store and the running peak.
  hla_dp #(
    .THETA_BINS (THETA_BINS),
    .RHO_BINS   (RHO_BINS),
    .VOTE_BITS  (VOTE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pixel_value      (in_pixel_value),
    .pos_x            (in_pos_x),
    .pos_y            (in_pos_y),
    .cmd              (cmd),
    .sts              (sts),
    .peak_theta_index (out_peak_theta_index),
    .peak_rho_index   (out_peak_rho_index),
    .peak_votes       (out_peak_votes),
    .votes_saturated  (out_votes_saturated)
  );

endmodule

@@ sv/hla_checker.sv @@
// Port-level checker of the Hough line accumulator and its bind.
`include "hough_line_accumulator_assert.svh"

module hla_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [7:0]  in_pixel_value,
  input logic        in_frame_first,
  input logic        in_frame_last,
  input logic        out_valid,
  input logic [6:0]  out_peak_theta_index,
  input logic [7:0]  out_peak_rho_index,
  input logic [31:0] out_peak_votes
);

  `HLA_ASSERT_SAME(a_result_while_busy, out_valid, busy, "result strobe outside busy")
  `HLA_ASSERT_NEXT(a_strobe_one_cycle, out_valid, !out_valid, "result strobe held")
  `HLA_ASSERT_NEXT(a_work_sets_busy, start && !busy && (in_frame_first || in_frame_last || in_pixel_value != 8'd0), busy, "working item did not raise busy")
  `HLA_ASSERT_HOLDS(a_empty_peak_zero, !out_valid || out_peak_votes != 32'd0 || (out_peak_theta_index == 7'd0 && out_peak_rho_index == 8'd0), "empty store gave nonzero peak index")

endmodule

bind hough_line_accumulator hla_checker u_hla_checker (.*);

@@ sim/hough_line_accumulator_tb.sv @@
// Self-checking testbench of the Hough line accumulator: directed and random frames.
`timescale 1ns / 100ps

module testbench;

  localparam int NTHETA     = 128;
  localparam int NRHO       = 256;
  localparam int NCELLS     = NTHETA * NRHO;
  localparam int STALL_LIMIT = 200000;
  localparam longint unsigned VOTE_CAP = 64'hFFFF_FFFF;

  typedef struct {
    logic [7:0] value;
    logic [9:0] x;
    logic [9:0] y;
    logic       first;
    logic       last;
  } pixel_item_t;

  typedef struct {
    logic [6:0]  theta;
    logic [7:0]  rho;
    logic [31:0] votes;
    logic        sat;
  } line_peak_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hla_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hla_pkg::CFG_W-1:0] cfg_wdata;
  logic start;
  logic busy;
  logic busy_q;
  logic [7:0] in_pixel_value;
  logic [9:0] in_pos_x;
  logic [9:0] in_pos_y;
  logic in_frame_first;
  logic in_frame_last;
  logic out_valid;
  logic [6:0] out_peak_theta_index;
  logic [7:0] out_peak_rho_index;
  logic [31:0] out_peak_votes;
  logic out_votes_saturated;

  hough_line_accumulator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_pixel_value(in_pixel_value), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_frame_first(in_frame_first), .in_frame_last(in_frame_last),
    .out_valid(out_valid),
    .out_peak_theta_index(out_peak_theta_index),
    .out_peak_rho_index(out_peak_rho_index),
    .out_peak_votes(out_peak_votes),
    .out_votes_saturated(out_votes_saturated)
  );

  // Predictor state: trig tables, registers, vote store, saturation flag.
  longint sin_q15 [NTHETA];
  longint cos_q15 [NTHETA];
  longint unsigned votes [NCELLS];
  bit sat_flag;
  logic [10:0] img_w;
  logic [10:0] img_h;
  logic [25:0] rho_off;
  logic [23:0] rho_scl;

  pixel_item_t pending_pixels [$];
  line_peak_t  expected_peaks [$];
  int idle_pct;
  int fails;
  int items_taken;
  int peaks_seen;
  int stall_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Round a Q2.30 series sum to 2^-15 units, clamped to [0, 1.0].
  function automatic longint round_q15(longint v);
    if (v < 0) v = 0;
    v = (v + 16384) / 32768;
    if (v > 32768) v = 32768;
    return v;
  endfunction

  // Fill sine/cosine of pi*t/NTHETA from a truncated Taylor series on [0, pi/2].
  task automatic build_angle_tables();
    longint unsigned k, ang, ang2, st, ct;
    longint ss, cs;
    bit mirror;
    for (int t = 0; t < NTHETA; t++) begin
      k = t;
      mirror = 1'b0;
      if (2 * t > NTHETA) begin
        k = NTHETA - t;
        mirror = 1'b1;
      end
      ang  = (64'hC90FDAA2 * k) / NTHETA;
      ang2 = (ang * ang) >> 30;
      st = ang;
      ct = 64'd1 << 30;
      ss = longint'(st);
      cs = longint'(ct);
      for (int n = 1; n <= 14; n++) begin
        st = ((st * ang2) >> 30) / ((2 * n) * (2 * n + 1));
        ct = ((ct * ang2) >> 30) / ((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          ss -= longint'(st);
          cs -= longint'(ct);
        end else begin
          ss += longint'(st);
          cs += longint'(ct);
        end
      end
      sin_q15[t] = round_q15(ss);
      cos_q15[t] = mirror ? -round_q15(cs) : round_q15(cs);
    end
  endtask

  // Apply one pixel to the vote store; queue the peak if it closes a frame.
  task automatic cast_votes(pixel_item_t p);
    longint dx, dy, r15, s;
    longint unsigned bin, sum, best;
    int bt, br;
    dx = longint'(p.x) - longint'(img_w / 2);
    dy = longint'(p.y) - longint'(img_h / 2);
    if (p.first) begin
      foreach (votes[i]) votes[i] = 0;
      sat_flag = 1'b0;
    end
    if (p.value != 0) begin
      for (int t = 0; t < NTHETA; t++) begin
        r15 = dx * sin_q15[t] - dy * cos_q15[t];
        s = 2 * r15 + longint'(rho_off);
        bin = 0;
        if (s > 0) begin
          bin = (longint'(s) * longint'(rho_scl)) >> 32;
          if (bin > NRHO - 1) bin = NRHO - 1;
        end
        sum = votes[t * NRHO + bin] + p.value;
        if (sum >= VOTE_CAP) begin
          sum = VOTE_CAP;
          sat_flag = 1'b1;
        end
        votes[t * NRHO + bin] = sum;
      end
    end
    if (p.last) begin
      best = 0;
      bt = 0;
      br = 0;
      for (int t = 0; t < NTHETA; t++)
        for (int r = 0; r < NRHO; r++)
          if (votes[t * NRHO + r] > best) begin
            best = votes[t * NRHO + r];
            bt = t;
            br = r;
          end
      expected_peaks.push_back('{7'(bt), 8'(br), 32'(best), sat_flag});
    end
  endtask

  // Busy as seen at the last rising edge; tells the driver whether its item was taken.
  always @(posedge clk) begin
    busy_q <= busy;
  end

  // Driver: present the next pixel at the falling edge, idling at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy_q) begin
      if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        pixel_item_t p;
        p = pending_pixels.pop_front();
        in_pixel_value <= p.value;
        in_pos_x       <= p.x;
        in_pos_y       <= p.y;
        in_frame_first <= p.first;
        in_frame_last  <= p.last;
        start          <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: take accepted pixels into the predictor, check each peak, watch for stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        cast_votes('{in_pixel_value, in_pos_x, in_pos_y, in_frame_first, in_frame_last});
        items_taken++;
      end
      if (out_valid) begin
        if (expected_peaks.size() == 0) begin
          $display("%0t: unexpected peak theta=%0d rho=%0d votes=%0d sat=%0d", $time,
                   out_peak_theta_index, out_peak_rho_index, out_peak_votes,
                   out_votes_saturated);
          fails++;
        end else begin
          line_peak_t e;
          e = expected_peaks.pop_front();
          peaks_seen++;
          if (out_peak_theta_index !== e.theta) begin
            $display("%0t: theta expected %0d got %0d", $time, e.theta,
                     out_peak_theta_index);
            fails++;
          end
          if (out_peak_rho_index !== e.rho) begin
            $display("%0t: rho expected %0d got %0d", $time, e.rho, out_peak_rho_index);
            fails++;
          end
          if (out_peak_votes !== e.votes) begin
            $display("%0t: votes expected %0d got %0d", $time, e.votes, out_peak_votes);
            fails++;
          end
          if (out_votes_saturated !== e.sat) begin
            $display("%0t: saturated expected %0d got %0d", $time, e.sat,
                     out_votes_saturated);
            fails++;
          end
        end
      end
    end
    // count cycles without any transfer; reset clear sweep is well under the limit
    if ((start && !busy) || out_valid || cfg_we) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Hold until every queued pixel is taken, the block is idle and no peak is owed.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || start);
    repeat (4) @(negedge clk);
    while (busy || expected_peaks.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [hla_pkg::CFG_IDX_W-1:0] idx,
                           logic [hla_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      hla_pkg::REG_IMAGE_WIDTH:  img_w   = val[10:0];
      hla_pkg::REG_IMAGE_HEIGHT: img_h   = val[10:0];
      hla_pkg::REG_RHO_OFFSET:   rho_off = val[25:0];
      default:                   rho_scl = val[23:0];
    endcase
  endtask

  task automatic set_geometry(int w, int h, int off, int scl);
    write_reg(hla_pkg::REG_IMAGE_WIDTH, hla_pkg::CFG_W'(w));
    write_reg(hla_pkg::REG_IMAGE_HEIGHT, hla_pkg::CFG_W'(h));
    write_reg(hla_pkg::REG_RHO_OFFSET, hla_pkg::CFG_W'(off));
    write_reg(hla_pkg::REG_RHO_SCALE, hla_pkg::CFG_W'(scl));
  endtask

  task automatic push_pixel(int v, int x, int y, bit f, bit l);
    pending_pixels.push_back('{8'(v), 10'(x), 10'(y), f, l});
  endtask

  // One random frame: mostly in-image pixels, some blanks, a few strays.
  task automatic push_frame();
    int len, v, x, y;
    bit f;
    len = $urandom_range(4, 20);
    for (int i = 0; i < len; i++) begin
      v = ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(1, 255);
      if ($urandom_range(0, 99) < 85) begin
        x = $urandom_range(0, (img_w > 1024 ? 1024 : img_w) - 1);
        y = $urandom_range(0, (img_h > 1024 ? 1024 : img_h) - 1);
      end else begin
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, 1023);
      end
      // most frames open with a clear; the rest add to the old store unless a later pixel clears it
      f = (i == 0) ? ($urandom_range(0, 99) < 60) : ($urandom_range(0, 99) < 2);
      push_pixel(v, x, y, f, i == len - 1);
    end
  endtask

  initial begin
    int phase_items;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 1'b0;
    in_pixel_value = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_frame_first = 1'b0;
    in_frame_last = 1'b0;
    fails = 0;
    items_taken = 0;
    peaks_seen = 0;
    stall_cnt = 0;
    idle_pct = 22;
    img_w = hla_pkg::IMAGE_WIDTH_RST;
    img_h = hla_pkg::IMAGE_HEIGHT_RST;
    rho_off = hla_pkg::RHO_OFFSET_RST;
    rho_scl = hla_pkg::RHO_SCALE_RST;
    sat_flag = 1'b0;
    foreach (votes[i]) votes[i] = 0;
    build_angle_tables();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset geometry: empty frame, corner pixels, appended frame, tied pixels.
    push_pixel(0, 0, 0, 1, 1);
    push_pixel(255, 0, 0, 1, 0);
    push_pixel(255, 1023, 1023, 0, 0);
    push_pixel(1, 320, 240, 0, 0);
    push_pixel(128, 639, 479, 0, 1);
    push_pixel(7, 1023, 0, 0, 1);
    push_pixel(10, 100, 100, 1, 0);
    push_pixel(10, 100, 100, 0, 1);
    wait_drained();

    // Zero offset drives rho negative; full scale pushes it past the last bin.
    set_geometry(1024, 1024, 0, 24'hFFFFFF);
    push_pixel(255, 0, 1023, 1, 0);
    push_pixel(200, 1023, 0, 0, 0);
    push_pixel(9, 512, 512, 0, 1);
    wait_drained();

    // Tiny image: all pixels but the one at 0,0 lie outside; largest offset, smallest scale.
    set_geometry(2, 2, 26'h3FFFFFF, 1);
    push_pixel(255, 1023, 1023, 1, 0);
    push_pixel(3, 0, 0, 0, 0);
    push_pixel(170, 682, 341, 0, 1);
    wait_drained();

    // Random phases; each closes with a full drain before the next settings.
    phase_items = 0;
    for (int ph = 0; phase_items < 500; ph++) begin
      idle_pct = (phase_items < 170) ? 22 : (phase_items < 340) ? 71 : 0;
      case (ph % 4)
        0: set_geometry(hla_pkg::IMAGE_WIDTH_RST, hla_pkg::IMAGE_HEIGHT_RST,
                        hla_pkg::RHO_OFFSET_RST, hla_pkg::RHO_SCALE_RST);
        1: set_geometry($urandom_range(2, 1024), $urandom_range(2, 1024),
                        $urandom_range(0, 26'h3FFFFFF), $urandom_range(1, 24'hFFFFFF));
        2: set_geometry(1024, 1024, 26'h3FFFFFF, 24'd32768);
        default: set_geometry($urandom_range(100, 1024), $urandom_range(100, 1024),
                              $urandom_range(1 << 24, 26'h3FFFFFF),
                              $urandom_range(1 << 12, 1 << 16));
      endcase
      for (int fr = 0; fr < 4; fr++) begin
        phase_items -= pending_pixels.size();
        push_frame();
        phase_items += pending_pixels.size();
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("Covered %0d pixels and %0d peak results over directed and random frames,",
             items_taken, peaks_seen);
    $display("with register sets at their limits and sender idling at 22, 71 and 0 percent.");
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
